// ----- design/nrld_pkg.sv -----
// Package for the nibble run-length decoder: widths, code constants,
// the queue entry type and the code byte classifier.
// No dependencies; every module of the decoder imports it.
`default_nettype none

package nrld_pkg;

    localparam int COUNT_BITS = 24;
    localparam int FRAME_W    = 24;
    localparam int CMP_W      = ((COUNT_BITS > FRAME_W) ? COUNT_BITS : FRAME_W) + 1;

    localparam logic [CMP_W-1:0] CNT_FULL = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_IDX_FRAME_BYTES = 1'b0;
    localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET = FRAME_W'(1);

    localparam logic [3:0] NIB_RUN_ZERO = 4'h0;
    localparam logic [3:0] NIB_RUN_ONES = 4'hF;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int REM_W = 5;

    typedef struct packed {
        logic [3:0] hi;
        logic [3:0] lo;
        logic       is_run;
    } code_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic code_entry_t classify(input logic [7:0] code);
        code_entry_t e;
        e.hi     = code[7:4];
        e.lo     = code[3:0];
        e.is_run = (code[7:4] == NIB_RUN_ZERO) || (code[7:4] == NIB_RUN_ONES);
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- design/nrld_front.sv -----
// Front end of the nibble run-length decoder: accepts code bytes and
// classifies each one as a run or a literal pair for the queue.
// Depends on nrld_pkg.
`default_nettype none

module nrld_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,    // code_byte
    input  wire logic                 q_full,
    output logic                      q_push,
    output nrld_pkg::code_entry_t     q_entry
);
    import nrld_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_entry  = classify(s_tdata);

endmodule

`default_nettype wire

// ----- design/nrld_queue.sv -----
// Short queue of classified code bytes between the front and back ends.
// Depends on nrld_pkg.
`default_nettype none

module nrld_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire nrld_pkg::code_entry_t push_entry,
    input  wire logic                  pop,
    output nrld_pkg::code_entry_t      head,
    output nrld_pkg::queue_stat_t      stat
);
    import nrld_pkg::*;

    code_entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;
    logic                    do_push;
    logic                    do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- design/nrld_back.sv -----
// Back end of the nibble run-length decoder: expands the queued code
// bytes into nibbles, pairs them into bytes and tracks the frame count.
// Depends on nrld_pkg.
`default_nettype none

module nrld_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nrld_pkg::code_entry_t         head,
    input  wire logic                          head_valid,
    output logic                               pop,
    input  wire logic [nrld_pkg::FRAME_W-1:0]  frame_bytes,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // pixel_byte
    output logic                               m_tlast,   // last_of_item
    output logic                               m_tuser    // frame_done
);
    import nrld_pkg::*;

    logic [REM_W-1:0]      idx_reg;
    logic [REM_W-1:0]      idx_next;
    logic [3:0]            pend_reg;
    logic [3:0]            pend_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            out_byte_reg;
    logic [7:0]            out_byte_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_done_reg;
    logic                  out_done_next;

    logic [REM_W-1:0]      total;
    logic [REM_W-1:0]      rem;
    logic [REM_W-1:0]      rem_after;
    logic [REM_W-1:0]      consumed;
    logic [3:0]            nib_a;
    logic [3:0]            nib_b;
    logic [3:0]            tail_nib;
    logic                  step;
    logic                  emit;
    logic [CMP_W-1:0]      cnt_plus;
    logic                  done;

    assign total     = head.is_run ? ({1'b0, head.lo} + REM_W'(1)) : REM_W'(2);
    assign rem       = total - idx_reg;
    assign nib_a     = (head.is_run || (idx_reg == '0)) ? head.hi : head.lo;
    assign nib_b     = head.is_run ? head.hi : head.lo;
    assign tail_nib  = head.is_run ? head.hi : head.lo;
    assign step      = head_valid && (!out_valid_reg || m_tready);
    assign emit      = pend_valid_reg || (rem >= REM_W'(2));
    assign consumed  = pend_valid_reg ? REM_W'(1) : REM_W'(2);
    assign rem_after = rem - consumed;
    assign cnt_plus  = CMP_W'(cnt_reg) + CMP_W'(1);
    assign done      = (cnt_plus >= CMP_W'(frame_bytes)) || (cnt_plus >= CNT_FULL);

    always_comb
    begin
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        pop             = 1'b0;
        if (step)
        begin
            if (!emit)
            begin
                pend_next       = nib_a;
                pend_valid_next = 1'b1;
                idx_next        = '0;
                pop             = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_valid_reg ? {pend_reg, nib_a} : {nib_a, nib_b};
                out_last_next  = done || (rem_after < REM_W'(2));
                out_done_next  = done;
                if (done)
                begin
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    pend_next       = '0;
                    idx_next        = '0;
                    pop             = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_plus[COUNT_BITS-1:0];
                    unique if (rem_after == '0)
                    begin
                        pend_valid_next = 1'b0;
                        pend_next       = '0;
                        idx_next        = '0;
                        pop             = 1'b1;
                    end
                    else if (rem_after == REM_W'(1))
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = tail_nib;
                        idx_next        = '0;
                        pop             = 1'b1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        pend_next       = '0;
                        idx_next        = idx_reg + consumed;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

`default_nettype wire

// ----- design/nibble_run_length_decoder_unit.sv -----
// Top level of the nibble run-length decoder: APB register, front end,
// queue and back end. Depends on nrld_pkg, nrld_front, nrld_queue, nrld_back.
//
// Each code byte on the slave stream is classified and queued; the back end
// then emits one decoded byte per cycle into an output register while the
// sink accepts: up to eight bytes per code byte, or no byte at all when the
// code byte only fills the pending nibble. The front end keeps taking
// code bytes while the two-entry queue has room. tlast marks the final byte
// of a code byte and tuser marks the byte that completes a frame of
// frame_bytes bytes (register at address 0, reset value 1).
`default_nettype none

module nibble_run_length_decoder_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // code_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // pixel_byte
    output logic                                   m_tlast,   // last_of_item
    output logic                                   m_tuser,   // frame_done
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nrld_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import nrld_pkg::*;

    logic [FRAME_W-1:0] frame_bytes_reg;
    logic [FRAME_W-1:0] frame_bytes_next;
    logic               cfg_wr;
    logic               q_push;
    logic               q_pop;
    code_entry_t        q_entry;
    code_entry_t        q_head;
    queue_stat_t        q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IDX_FRAME_BYTES) ? 32'(frame_bytes_reg) : 32'd0;

    always_comb
    begin
        frame_bytes_next = frame_bytes_reg;
        if (cfg_wr && (paddr[2] == REG_IDX_FRAME_BYTES))
        begin
            frame_bytes_next = pwdata[FRAME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_reg <= FRAME_BYTES_RESET;
        end
        else
        begin
            frame_bytes_reg <= frame_bytes_next;
        end
    end

    nrld_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    nrld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    nrld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_valid  (!q_stat.empty),
        .pop         (q_pop),
        .frame_bytes (frame_bytes_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end not marked as last byte of its code byte");

    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (paddr[2] == REG_IDX_FRAME_BYTES))
        |=> (frame_bytes_reg == $past(pwdata[FRAME_W-1:0])))
        else $error("frame length register not updated by write");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end consumed from an empty queue");

endmodule

`default_nettype wire
